>>> src/slht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_pkg
// Shared types, constants and tables of the slew limited heading tracker.
// ----------------------------------------------------------------------------
package slht_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_TABLE_LEN   = 24;
  localparam int QUEUE_DEPTH      = 4;

  // Datapath width of the CORDIC x and y registers: 17 bits of offset, 20 bits
  // of fraction and headroom for the CORDIC gain.
  localparam int CORDIC_XW = 40;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TURN_SPEED = 2'd0;
  localparam logic [1:0] CFG_CENTER_X   = 2'd1;
  localparam logic [1:0] CFG_CENTER_Y   = 2'd2;

  localparam logic [15:0] TURN_SPEED_RST = 16'd2731;
  localparam logic [11:0] CENTER_X_RST   = 12'd400;
  localparam logic [11:0] CENTER_Y_RST   = 12'd300;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  localparam logic [31:0] ATAN_TURN32 [ATAN_TABLE_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic        [20:0] elapsed;
  } hdg_in_t;

  typedef struct packed {
    logic [15:0] heading_out;
    logic [15:0] target_angle;
  } hdg_out_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> src/slew_limited_heading_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slew_limited_heading_tracker_core
// Points a heading toward a target point at a bounded turn rate.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): target point and elapsed time.
// Output channel (out_valid/out_stall/out_data): new heading and the angle
// toward the target, one result per item, in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// the turn speed, 1 the center x, 2 the center y; cfg_ready is always high.
// Write configuration only while no item is in flight.
// Throughput: one item per cycle while the output is not stalled. The CORDIC
// is fully pipelined, one stage per iteration, and the heading update is a
// combinational step around the heading register in the back end. An item
// passes the entry, CORDIC, rounding, queue head and output registers in turn.
// Reset clears the pipeline, the queue and the heading, and loads the
// configuration defaults. When the receiver stalls, the result register holds,
// the queue fills, and then the front stalls the input.
// ----------------------------------------------------------------------------
module slew_limited_heading_tracker_core import slht_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  hdg_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hdg_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] turn_speed;
  logic [11:0] center_x;
  logic [11:0] center_y;

  q_status_t               q_status;
  logic                    push;
  logic                    pop;
  logic [2*ANGLE_BITS-1:0] push_data;
  logic [2*ANGLE_BITS-1:0] pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_speed <= TURN_SPEED_RST;
      center_x   <= CENTER_X_RST;
      center_y   <= CENTER_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TURN_SPEED: turn_speed <= cfg_data;
        CFG_CENTER_X:   center_x   <= cfg_data[11:0];
        CFG_CENTER_Y:   center_y   <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  slht_front #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .turn_speed (turn_speed),
    .center_x   (center_x),
    .center_y   (center_y),
    .q_status   (q_status),
    .pop        (pop),
    .push       (push),
    .push_data  (push_data)
  );

  slht_queue #(
    .W (2 * ANGLE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_status  (q_status)
  );

  slht_back #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/slht_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_front
// Accepts items, centers the target, prepares the step limit and runs the
// pipelined CORDIC that yields the target angle.
// ----------------------------------------------------------------------------
module slht_front import slht_pkg::*; #(
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  hdg_in_t                   in_data,
  input  logic [15:0]               turn_speed,
  input  logic [11:0]               center_x,
  input  logic [11:0]               center_y,
  input  q_status_t                 q_status,
  input  logic                      pop,
  output logic                      push,
  output logic [2*ANGLE_BITS-1:0]   push_data
);

  localparam int NS = (CORDIC_STEPS < ATAN_TABLE_LEN) ? CORDIC_STEPS : ATAN_TABLE_LEN;
  localparam int XW = CORDIC_XW;
  localparam int LW = (ANGLE_BITS > 17) ? ANGLE_BITS + 1 : 18;
  localparam logic [LW-1:0] HALF = LW'(1) << (ANGLE_BITS - 1);
  localparam logic [31:0]   ROUND_BIAS = 32'd1 << (31 - ANGLE_BITS);

  logic en;

  // Entry stage: offsets from the center and the raw turn product.
  logic               e_valid;
  logic signed [16:0] e_dx;
  logic signed [16:0] e_dy;
  logic        [36:0] e_prod;

  // CORDIC stages.
  logic [NS:0]              pv;
  logic signed [XW-1:0]     px [0:NS];
  logic signed [XW-1:0]     py [0:NS];
  logic [31:0]              pa [0:NS];
  logic                     pz [0:NS];
  logic [ANGLE_BITS-1:0]    pl [0:NS];

  // Rounding stage.
  logic                  r_valid;
  logic [ANGLE_BITS-1:0] r_target;
  logic [ANGLE_BITS-1:0] r_limit;

  logic signed [XW-1:0]  sx;
  logic signed [XW-1:0]  sy;
  logic [LW-1:0]         lim_ext;
  logic [ANGLE_BITS-1:0] lim_sat;
  logic [31:0]           rsum;

  // The whole pipeline holds only when its last item cannot enter the queue.
  assign en       = !(r_valid && q_status.full && !pop);
  assign in_stall = !en;
  assign push     = r_valid && en;
  assign push_data = {r_target, r_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      pv      <= '0;
      r_valid <= 1'b0;
    end else if (en) begin
      e_valid <= in_valid;
      pv      <= {pv[NS-1:0], e_valid};
      r_valid <= pv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_dx   <= {in_data.target_x[15], in_data.target_x} - {5'b0, center_x};
      e_dy   <= {in_data.target_y[15], in_data.target_y} - {5'b0, center_y};
      e_prod <= turn_speed * in_data.elapsed;
    end
  end

  always_comb begin
    sx      = {{(XW-37){e_dx[16]}}, e_dx, 20'b0};
    sy      = {{(XW-37){e_dy[16]}}, e_dy, 20'b0};
    lim_ext = LW'(e_prod[36:20]);
    lim_sat = (lim_ext > HALF) ? HALF[ANGLE_BITS-1:0] : lim_ext[ANGLE_BITS-1:0];
  end

  // A target in the left half plane is turned by half a turn first.
  always_ff @(posedge clk) begin
    if (en) begin
      if (e_dx[16]) begin
        px[0] <= -sx;
        py[0] <= -sy;
        pa[0] <= 32'h8000_0000;
      end else begin
        px[0] <= sx;
        py[0] <= sy;
        pa[0] <= 32'd0;
      end
      pz[0] <= (e_dx == '0) && (e_dy == '0);
      pl[0] <= lim_sat;
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic                 ypos;
    assign xs   = px[i] >>> i;
    assign ys   = py[i] >>> i;
    assign ypos = !py[i][XW-1] && (py[i] != '0);
    always_ff @(posedge clk) begin
      if (en) begin
        if (ypos) begin
          px[i+1] <= px[i] + ys;
          py[i+1] <= py[i] - xs;
          pa[i+1] <= pa[i] + ATAN_TURN32[i];
        end else begin
          px[i+1] <= px[i] - ys;
          py[i+1] <= py[i] + xs;
          pa[i+1] <= pa[i] - ATAN_TURN32[i];
        end
        pz[i+1] <= pz[i];
        pl[i+1] <= pl[i];
      end
    end
  end

  assign rsum = pa[NS] + ROUND_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      r_target <= pz[NS] ? '0 : rsum[31 -: ANGLE_BITS];
      r_limit  <= pl[NS];
    end
  end

endmodule

>>> src/slht_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_queue
// Short FIFO that decouples the CORDIC front from the heading update.
// ----------------------------------------------------------------------------
module slht_queue import slht_pkg::*; #(
  parameter int W = 2 * ANGLE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output q_status_t    q_status
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW-1:0] rd_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign q_status.full  = (count == CW'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    rd_next = rd_ptr;
    if (pop) begin
      rd_next = (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      rd_ptr <= rd_next;
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
    end
  end

  // The head entry is kept in a register; a transfer into the slot that
  // becomes the head is passed straight through.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (push && (wr_ptr == rd_next)) begin
      pop_data <= push_data;
    end else begin
      pop_data <= mem[rd_next];
    end
  end

endmodule

>>> src/slht_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_back
// Turns the stored heading toward the target angle within the step limit and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module slht_back import slht_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  q_status_t               q_status,
  input  logic [2*ANGLE_BITS-1:0] pop_data,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output hdg_out_t                out_data
);

  logic [ANGLE_BITS-1:0] heading;
  logic [ANGLE_BITS-1:0] heading_next;
  logic [ANGLE_BITS-1:0] target;
  logic [ANGLE_BITS-1:0] limit;
  logic [ANGLE_BITS-1:0] diff;
  logic [ANGLE_BITS-1:0] mag;
  logic                  negative;
  logic [31:0]           hdg_ext;
  logic [31:0]           tgt_ext;

  assign pop = !q_status.empty && (!out_valid || !out_stall);
  assign {target, limit} = pop_data;

  // A difference of exactly half a turn counts as a negative turn; its
  // magnitude is then half a turn as well.
  always_comb begin
    diff     = target - heading;
    negative = diff[ANGLE_BITS-1];
    mag      = negative ? (~diff + 1'b1) : diff;
    if (mag <= limit) begin
      heading_next = target;
    end else if (negative) begin
      heading_next = heading - limit;
    end else begin
      heading_next = heading + limit;
    end
    hdg_ext = 32'(heading_next);
    tgt_ext = 32'(target);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      heading   <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
        heading   <= heading_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.heading_out  <= hdg_ext[15:0];
      out_data.target_angle <= tgt_ext[15:0];
    end
  end

endmodule

>>> src/slht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slht_checker
// Port-level checks of the heading tracker, bound to the top level.
// ----------------------------------------------------------------------------
module slht_checker import slht_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input hdg_out_t out_data,
  input logic     cfg_ready
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Input backpressure only ever comes from a stalled output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while output drains");

  // Reset leaves no result valid and the input unstalled.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // The configuration port never refuses a write; checked while an item is offered.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> cfg_ready)
    else $error("configuration port not ready");

endmodule

bind slew_limited_heading_tracker_core slht_checker u_slht_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);

>>> tb/sv/tb_slew_limited_heading_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slew_limited_heading_tracker_core
// Self-checking bench for the slew limited heading tracker core.
// Drives target points through several turn speed and center settings, and
// stalls both channels at random. A scoreboard tracks the heading on its
// own, measures every target angle with its own CORDIC, and checks each
// result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb_slew_limited_heading_tracker_core;
  import slht_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int DRAIN_CYCLES = CORDIC_STEPS_DEF + 8;

  class heading_scoreboard;
    logic [15:0] speed;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [15:0] heading;
    hdg_out_t expected_headings[$];
    int errors;

    function new();
      speed = TURN_SPEED_RST;
      cx = CENTER_X_RST;
      cy = CENTER_Y_RST;
      heading = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_TURN_SPEED: speed = val;
        CFG_CENTER_X: cx = val[11:0];
        CFG_CENTER_Y: cy = val[11:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_headings.size();
    endfunction

    // Vectoring CORDIC on the offset, scaled by 2^20, angle kept in 2^-32 turn.
    function logic [15:0] bearing(longint dx, longint dy);
      longint x;
      longint y;
      longint nx;
      logic [31:0] acc;
      logic [32:0] sum;
      if (dx == 0 && dy == 0) begin
        return 16'd0;
      end
      x = dx * 64'sd1048576;
      y = dy * 64'sd1048576;
      acc = '0;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_TABLE_LEN; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          acc = acc + ATAN_TURN32[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          acc = acc - ATAN_TURN32[i];
        end
        x = nx;
      end
      sum = {1'b0, acc} + 33'd32768;
      return sum[31:16];
    endfunction

    function void note_target(hdg_in_t it);
      longint dx;
      longint dy;
      logic [15:0] tgt;
      logic [15:0] diff;
      logic [16:0] mag;
      logic [36:0] prod;
      logic [16:0] lim;
      logic turn_neg;
      hdg_out_t res;
      dx = longint'($signed(it.target_x)) - longint'(cx);
      dy = longint'($signed(it.target_y)) - longint'(cy);
      tgt = bearing(dx, dy);
      prod = 37'(speed) * 37'(it.elapsed);
      lim = prod[36:20];
      if (lim > 17'd32768) begin
        lim = 17'd32768;
      end
      diff = tgt - heading;
      // Exactly half a turn away counts as a turn in the negative direction.
      turn_neg = diff[15];
      mag = turn_neg ? {1'b0, 16'(-diff)} : {1'b0, diff};
      if (mag <= lim) begin
        heading = tgt;
      end else if (turn_neg) begin
        heading = heading - lim[15:0];
      end else begin
        heading = heading + lim[15:0];
      end
      res.heading_out = heading;
      res.target_angle = tgt;
      expected_headings.push_back(res);
    endfunction

    function void check_heading(hdg_out_t got);
      hdg_out_t exp_res;
      if (expected_headings.size() == 0) begin
        $error("unexpected result: heading_out %0d, target_angle %0d",
               got.heading_out, got.target_angle);
        errors++;
        return;
      end
      exp_res = expected_headings.pop_front();
      if (got.heading_out !== exp_res.heading_out) begin
        $error("heading_out: expected %0d, actual %0d", exp_res.heading_out,
               got.heading_out);
        errors++;
      end
      if (got.target_angle !== exp_res.target_angle) begin
        $error("target_angle: expected %0d, actual %0d", exp_res.target_angle,
               got.target_angle);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  hdg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hdg_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  heading_scoreboard sb = new();
  bit idle_on = 1'b1;
  int stuck_cycles = 0;
  logic signed [15:0] last_x = '0;
  logic signed [15:0] last_y = '0;

  slew_limited_heading_tracker_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_heading(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver stalls come in bursts; quiet windows between them vary in length.
  initial begin
    @(negedge rst);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  task automatic send_item(input hdg_in_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_target(it);
  endtask

  task automatic send_point(input int x, input int y, input int dt);
    hdg_in_t it;
    it.target_x = 16'(x);
    it.target_y = 16'(y);
    it.elapsed = 21'(dt);
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Registers change only with nothing in flight.
  task automatic apply_settings(input logic [15:0] spd, input logic [15:0] x0,
                                input logic [15:0] y0);
    logic [1:0] idx [3];
    logic [15:0] val [3];
    wait_drained();
    idx = '{CFG_TURN_SPEED, CFG_CENTER_X, CFG_CENTER_Y};
    val = '{spd, x0, y0};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.set_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic hdg_in_t random_item();
    hdg_in_t it;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      it.target_x = 16'($urandom);
      it.target_y = 16'($urandom);
    end else if (pick < 7) begin
      // Close to the pivot, including the pivot itself.
      it.target_x = 16'(int'(sb.cx) + $urandom_range(0, 16) - 8);
      it.target_y = 16'(int'(sb.cy) + $urandom_range(0, 16) - 8);
    end else begin
      // Hold the target so the heading has time to converge.
      it.target_x = last_x;
      it.target_y = last_y;
    end
    last_x = it.target_x;
    last_y = it.target_y;
    case ($urandom_range(0, 5))
      0: it.elapsed = '0;
      1: it.elapsed = 21'($urandom_range(0, 4096));
      2: it.elapsed = 21'($urandom_range(16000, 20000));
      3: it.elapsed = 21'($urandom_range(1000000, 1100000));
      default: it.elapsed = 21'($urandom);
    endcase
    return it;
  endfunction

  task automatic run_random(input int count, input bit with_pause);
    for (int n = 0; n < count; n++) begin
      if (with_pause && n == count / 2) begin
        wait_drained();
      end
      send_item(random_item());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: pivot, opposite heading, field extremes, axis neighbors.
    send_point(400, 300, 0);
    send_point(0, 300, 0);
    send_point(0, 300, 1000);
    send_point(-32768, -32768, 21'h1FFFFF);
    send_point(32767, 32767, 1 << 20);
    send_point(-32768, 32767, 17476);
    send_point(32767, -32768, 0);
    send_point(401, 300, 21'h1FFFFF);
    send_point(400, 301, 1 << 20);
    send_point(399, 300, 50000);
    send_point(400, 299, 1);
    send_point(-1, -1, 1 << 20);

    // Fastest turn: with a long elapsed time the limit saturates and the heading lands on the target.
    apply_settings(16'hFFFF, 16'd0, 16'd0);
    send_point(0, 0, 1 << 20);
    send_point(-5, 0, 21'h1FFFFF);
    send_point(0, -32768, 1);
    send_point(32767, 0, 21'h1FFFFF);
    send_point(-32768, -1, 1 << 20);
    run_random(350, 1'b0);

    // Zero speed with the pivot at the far corner.
    apply_settings(16'd0, 16'd4095, 16'd4095);
    run_random(300, 1'b1);

    // Upper center bits are dropped by the registers.
    apply_settings(16'($urandom), 16'($urandom), 16'($urandom));
    run_random(350, 1'b0);

    apply_settings(16'($urandom_range(1000, 8000)), 16'($urandom_range(0, 4095)),
                   16'($urandom_range(0, 4095)));
    idle_on = 1'b0;
    run_random(300, 1'b0);

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
